// ===== sv/lik_pkg.sv =====
// Shared widths, angle constants and the CORDIC arctangent table for the leg IK pipeline.
package lik_pkg;

    // Default number of CORDIC micro-rotations
    localparam int CORDIC_STEPS_DEF = 16;

    // Field widths
    localparam int COORD_W = 16;
    localparam int LEN_W   = 14;
    localparam int FRAC_SH = 8;
    localparam int COXA_W  = 16;
    localparam int FEMUR_W = 17;
    localparam int TIBIA_W = 15;

    // Angles in units of 2^-16 degree
    localparam int ANG_W = 26;
    localparam logic signed [ANG_W-1:0] ANG_45  = 26'sd2949120;
    localparam logic signed [ANG_W-1:0] ANG_90  = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_180 = 26'sd11796480;

    // Ratio (acos argument) format, Q30 signed
    localparam int Q_FRAC = 30;
    localparam int RAT_W  = 32;
    localparam logic signed [RAT_W-1:0] Q_ONE = RAT_W'(1) << Q_FRAC;

    // Law-of-cosines numerator and denominator widths
    localparam int NUM_W = 51;
    localparam int DEN_W = 49;

    // Rounding to 0.01 degree and the out-of-reach femur angle
    localparam int CENTI_SCALE = 100;
    localparam int ROUND_HALF  = 32768;
    localparam int ROUND_SH    = 16;
    localparam logic signed [FEMUR_W-1:0] FEMUR_FALLBACK = 17'sd9000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_COXA  = 2'd0,
        CFG_FEMUR = 2'd1,
        CFG_TIBIA = 2'd2
    } t_cfg_idx;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [ANG_W-1:0] lik_atan(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:  val = 26'sd2949120;
            1:  val = 26'sd1740967;
            2:  val = 26'sd919879;
            3:  val = 26'sd466945;
            4:  val = 26'sd234379;
            5:  val = 26'sd117304;
            6:  val = 26'sd58666;
            7:  val = 26'sd29335;
            8:  val = 26'sd14668;
            9:  val = 26'sd7334;
            10: val = 26'sd3667;
            11: val = 26'sd1833;
            12: val = 26'sd917;
            13: val = 26'sd458;
            14: val = 26'sd229;
            15: val = 26'sd115;
            16: val = 26'sd57;
            17: val = 26'sd29;
            18: val = 26'sd14;
            19: val = 26'sd7;
            20: val = 26'sd4;
            21: val = 26'sd2;
            22: val = 26'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/lik_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage.
module lik_isqrt #(
    parameter int IN_W = 48
) (
    input  logic              i_clk,
    input  logic [IN_W-1:0]   i_val,
    output logic [IN_W/2-1:0] o_root
);

    localparam int N = IN_W / 2;
    localparam logic [IN_W-1:0] ONE = {{(IN_W-1){1'b0}}, 1'b1};

    logic [IN_W-1:0] r_v   [N];
    logic [IN_W-1:0] r_res [N];

    // One digit-pair step: returns {remainder, root}
    function automatic logic [2*IN_W-1:0] sq_step(input logic [IN_W-1:0] v,
                                                  input logic [IN_W-1:0] res,
                                                  input int k);
        logic [IN_W-1:0] bitv;
        logic [IN_W-1:0] cand;
        bitv = ONE << (IN_W - 2 - 2 * k);
        cand = res + bitv;
        if (v >= cand) begin
            return {v - cand, (res >> 1) + bitv};
        end
        return {v, res >> 1};
    endfunction

    // Advance every stage each cycle
    always_ff @(posedge i_clk) begin
        {r_v[0], r_res[0]} <= sq_step(i_val, '0, 0);
        for (int k = 1; k < N; k++) begin
            {r_v[k], r_res[k]} <= sq_step(r_v[k-1], r_res[k-1], k);
        end
    end

    assign o_root = r_res[N-1][N-1:0];

endmodule

// ===== sv/lik_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in 2^-16 degree units.
module lik_cordic import lik_pkg::*; #(
    parameter int W_IN  = 16,
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic signed [W_IN-1:0]  i_y,
    input  logic signed [W_IN-1:0]  i_x,
    output logic signed [ANG_W-1:0] o_angle
);

    localparam int W = W_IN + 3;

    logic signed [W-1:0]     r_x    [STEPS+1];
    logic signed [W-1:0]     r_y    [STEPS+1];
    logic signed [ANG_W-1:0] r_ang  [STEPS+1];
    logic                    r_zero [STEPS+1];

    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;

    assign xe = W'(i_x);
    assign ye = W'(i_y);

    // Fold the left half plane onto the right, then rotate toward y = 0
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (xe < 0) begin
            if (ye >= 0) begin
                r_x[0]   <= ye;
                r_y[0]   <= -xe;
                r_ang[0] <= ANG_90;
            end else begin
                r_x[0]   <= -ye;
                r_y[0]   <= xe;
                r_ang[0] <= -ANG_90;
            end
        end else begin
            r_x[0]   <= xe;
            r_y[0]   <= ye;
            r_ang[0] <= '0;
        end
        for (int i = 0; i < STEPS; i++) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_ang[i+1] <= r_ang[i] + lik_atan(i);
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_ang[i+1] <= r_ang[i] - lik_atan(i);
            end
        end
    end

    // The origin maps to zero
    assign o_angle = r_zero[STEPS] ? '0 : r_ang[STEPS];

endmodule

// ===== sv/lik_ratio.sv =====
// Pipelined restoring divider giving num/den as Q30, clamped to [-1, 1].
module lik_ratio import lik_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic signed [RAT_W-1:0] o_ratio
);

    localparam int R_W = DEN_W + 1;

    logic             r_neg0;
    logic [NUM_W-1:0] r_mag0;
    logic [DEN_W-1:0] r_den0;
    logic             r_dz0;

    logic [R_W-1:0]    r_rem   [Q_FRAC+1];
    logic [Q_FRAC-1:0] r_q     [Q_FRAC+1];
    logic [DEN_W-1:0]  r_den   [Q_FRAC+1];
    logic              r_neg   [Q_FRAC+1];
    logic              r_clamp [Q_FRAC+1];

    logic signed [RAT_W-1:0] r_out;
    logic signed [RAT_W-1:0] q_ext;

    assign q_ext = RAT_W'(r_q[Q_FRAC]);

    always_ff @(posedge i_clk) begin
        // Split sign and magnitude
        r_neg0 <= i_num < 0;
        r_mag0 <= (i_num < 0) ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_den0 <= i_den;
        r_dz0  <= i_den == '0;

        // Clamp on a zero denominator or a magnitude of one or more
        r_clamp[0] <= r_dz0 || (r_mag0 >= NUM_W'(r_den0));
        r_rem[0]   <= R_W'(r_mag0);
        r_q[0]     <= '0;
        r_den[0]   <= r_den0;
        r_neg[0]   <= r_neg0;

        // One quotient bit per stage
        for (int k = 0; k < Q_FRAC; k++) begin
            r_den[k+1]   <= r_den[k];
            r_neg[k+1]   <= r_neg[k];
            r_clamp[k+1] <= r_clamp[k];
            if ({r_rem[k][R_W-2:0], 1'b0} >= R_W'(r_den[k])) begin
                r_rem[k+1] <= {r_rem[k][R_W-2:0], 1'b0} - R_W'(r_den[k]);
                r_q[k+1]   <= {r_q[k][Q_FRAC-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= {r_rem[k][R_W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][Q_FRAC-2:0], 1'b0};
            end
        end

        // Apply sign and clamp
        if (r_clamp[Q_FRAC]) begin
            r_out <= r_neg[Q_FRAC] ? -Q_ONE : Q_ONE;
        end else begin
            r_out <= r_neg[Q_FRAC] ? -q_ext : q_ext;
        end
    end

    assign o_ratio = r_out;

endmodule

// ===== sv/lik_acos.sv =====
// Pipelined acos(c) = atan2(sqrt(1 - c*c), c) for a Q30 argument.
module lik_acos import lik_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic signed [RAT_W-1:0] i_c,
    output logic signed [ANG_W-1:0] o_angle
);

    localparam int M_W   = Q_FRAC + 1;
    localparam int SQ_W  = 2 * M_W;
    localparam int C_DLY = 3 + SQ_W / 2;
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * Q_FRAC);

    logic [M_W-1:0]          r_m;
    logic [SQ_W-1:0]         r_mm;
    logic [SQ_W-1:0]         r_v;
    logic [SQ_W-1:0]         mm;
    logic signed [RAT_W-1:0] r_cd [C_DLY];
    logic [SQ_W/2-1:0]       root;
    logic signed [RAT_W-1:0] s_y;

    assign mm = r_m * r_m;

    always_ff @(posedge i_clk) begin
        // Magnitude, square, complement
        r_m  <= (i_c < 0) ? M_W'(-i_c) : M_W'(i_c);
        r_mm <= mm;
        r_v  <= ONE_SQ - r_mm;
        // Hold the argument alongside the root
        r_cd[0] <= i_c;
        for (int k = 1; k < C_DLY; k++) begin
            r_cd[k] <= r_cd[k-1];
        end
    end

    lik_isqrt #(.IN_W(SQ_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r_v),
        .o_root (root)
    );

    assign s_y = RAT_W'(root);

    lik_cordic #(.W_IN(RAT_W), .STEPS(STEPS)) u_atan (
        .i_clk   (i_clk),
        .i_y     (s_y),
        .i_x     (r_cd[C_DLY-1]),
        .o_angle (o_angle)
    );

endmodule

// ===== sv/leg_inverse_kinematics_3dof_unit.sv =====
// Top level of the three-link leg inverse kinematics pipeline.
//
// A foot target (x, y, z in 0.1 mm) is taken at every clock edge where start is high;
// busy never rises, so one target per cycle streams through. Each result appears on the
// outputs for one cycle, marked by o_done. The pipeline depth is the length of the chain
// of pipelined units: the horizontal-reach square root, the leg-length square root, the
// 30-stage restoring divider, the 31-stage root inside acos and its CORDIC. Results come
// out in order and cannot be held off. Link lengths are written over the cfg channel,
// which is always ready; write them only while no target is in flight.
module leg_inverse_kinematics_3dof_unit import lik_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic signed [COORD_W-1:0] i_target_z,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [LEN_W-1:0]          i_cfg_data,
    output logic                      o_done,
    output logic signed [COXA_W-1:0]  o_coxa_angle,
    output logic signed [FEMUR_W-1:0] o_femur_angle,
    output logic [TIBIA_W-1:0]        o_tibia_angle,
    output logic                      o_out_of_reach
);

    // Stage positions, counted in cycles after the accepting edge
    localparam int LAT_C   = CORDIC_STEPS + 1;
    localparam int LAT_RAT = Q_FRAC + 3;
    localparam int LAT_AC  = 3 + (Q_FRAC + 1) + CORDIC_STEPS + 1;
    localparam int L2_W    = 2 * COORD_W;
    localparam int LQ_IN_W = L2_W + 2 * FRAC_SH;
    localparam int LQ_W    = LQ_IN_W / 2;
    localparam int LP_W    = LQ_W + 1;
    localparam int ZQ_W    = COORD_W + FRAC_SH;
    localparam int D2_W    = 2 * LP_W;
    localparam int DQ_W    = D2_W / 2;
    localparam int FQ_W    = LEN_W + FRAC_SH;
    localparam int I_R2    = 2;
    localparam int I_REACH = 3;
    localparam int I_LQ    = I_R2 + LQ_W;
    localparam int I_LP    = I_LQ + 1;
    localparam int I_D2    = I_LP + 2;
    localparam int I_DQ    = I_D2 + DQ_W;
    localparam int I_ND    = I_DQ + 2;
    localparam int I_C     = I_ND + LAT_RAT;
    localparam int I_AC    = I_C + LAT_AC;
    localparam int I_A1    = I_LP + LAT_C;
    localparam int D_Z     = I_LQ;
    localparam int D_COXA  = I_AC - LAT_C;
    localparam int D_A1    = I_AC - I_A1;
    localparam int D_REACH = I_AC + 2 - I_REACH;
    localparam int NV      = I_AC + 4;
    localparam int RND_W   = ANG_W + 8;
    localparam int CEN_W   = RND_W - ROUND_SH;

    // Link lengths
    logic [LEN_W-1:0]   r_coxa;
    logic [LEN_W-1:0]   r_femur;
    logic [LEN_W-1:0]   r_tibia;
    logic [LEN_W+1:0]   reach_sum;
    logic [2*LEN_W+3:0] reach_sq;
    logic [2*LEN_W+3:0] r_reach2;

    // Valid beats travel down this line
    logic r_vld [NV];

    logic signed [COORD_W-1:0] r_x0;
    logic signed [COORD_W-1:0] r_y0;
    logic signed [COORD_W-1:0] r_z0;
    logic signed [L2_W-1:0]    xx_p;
    logic signed [L2_W-1:0]    yy_p;
    logic signed [L2_W-1:0]    zz_p;
    logic [L2_W-2:0]           r_xx;
    logic [L2_W-2:0]           r_yy;
    logic [L2_W-2:0]           r_zz;
    logic [L2_W-2:0]           r_zz2;
    logic [L2_W-1:0]           r_r2;
    logic                      r_reach;

    logic [LQ_W-1:0]           lq;
    logic signed [COORD_W-1:0] r_zd [D_Z];
    logic signed [LP_W-1:0]    r_lp;
    logic signed [ZQ_W-1:0]    r_zq;
    logic signed [LP_W-1:0]    zq_ext;
    logic signed [D2_W-1:0]    lp_sq;
    logic signed [2*ZQ_W-1:0]  zq_sq;
    logic [D2_W-2:0]           r_lp2;
    logic [2*ZQ_W-2:0]         r_zq2;
    logic [D2_W-1:0]           r_d2;

    logic [DQ_W-1:0]           dq;
    logic [FQ_W-1:0]           fq;
    logic [FQ_W-1:0]           tq;
    logic [2*FQ_W-1:0]         ff_p;
    logic [2*FQ_W-1:0]         tt_p;
    logic [2*FQ_W-1:0]         ft_p;
    logic [2*DQ_W-1:0]         dd_p;
    logic [FQ_W+DQ_W-1:0]      fd_p;
    logic [2*FQ_W-1:0]         r_ff;
    logic [2*FQ_W-1:0]         r_tt;
    logic [2*FQ_W-1:0]         r_ft;
    logic [2*DQ_W-1:0]         r_dd;
    logic [FQ_W+DQ_W-1:0]      r_fd;
    logic signed [NUM_W-1:0]   r_num1;
    logic signed [NUM_W-1:0]   r_num2;
    logic [DEN_W-1:0]          r_den1;
    logic [DEN_W-1:0]          r_den2;

    logic signed [RAT_W-1:0]   c1;
    logic signed [RAT_W-1:0]   c2;
    logic signed [ANG_W-1:0]   a2;
    logic signed [ANG_W-1:0]   b1;
    logic signed [ANG_W-1:0]   coxa_ang;
    logic signed [ANG_W-1:0]   a1;
    logic signed [ANG_W-1:0]   r_coxa_d [D_COXA];
    logic signed [ANG_W-1:0]   r_a1_d   [D_A1];
    logic                      r_reach_d [D_REACH];

    logic signed [ANG_W-1:0]   r_csum;
    logic signed [ANG_W-1:0]   r_fsum;
    logic signed [ANG_W-1:0]   r_tsum;
    logic                      r_cneg;
    logic                      r_fneg;
    logic                      r_tneg;
    logic [ANG_W-2:0]          r_cmag;
    logic [ANG_W-2:0]          r_fmag;
    logic [ANG_W-2:0]          r_tmag;
    logic signed [CEN_W:0]     c_cen;
    logic signed [CEN_W:0]     f_cen;
    logic signed [CEN_W:0]     t_cen;

    logic signed [COXA_W-1:0]  r_coxa_out;
    logic signed [FEMUR_W-1:0] r_femur_out;
    logic [TIBIA_W-1:0]        r_tibia_out;
    logic                      r_oor_out;

    // Round a magnitude in 2^-16 degree to 0.01 degree, halves away from zero
    function automatic logic signed [CEN_W:0] to_centi(input logic neg,
                                                       input logic [ANG_W-2:0] mag);
        logic [RND_W-1:0]  scaled;
        logic [CEN_W-1:0]  rnd;
        scaled = RND_W'(mag) * RND_W'(CENTI_SCALE) + RND_W'(ROUND_HALF);
        rnd    = scaled[RND_W-1:ROUND_SH];
        return neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coxa  <= 14'd500;
            r_femur <= 14'd800;
            r_tibia <= 14'd1200;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COXA:  r_coxa  <= i_cfg_data;
                CFG_FEMUR: r_femur <= i_cfg_data;
                CFG_TIBIA: r_tibia <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Squared total leg length, refreshed every cycle
    assign reach_sum = (LEN_W+2)'(r_coxa) + (LEN_W+2)'(r_femur) + (LEN_W+2)'(r_tibia);
    assign reach_sq  = reach_sum * reach_sum;

    always_ff @(posedge i_clk) begin
        r_reach2 <= reach_sq;
    end

    // Valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start;
            for (int k = 1; k < NV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Capture the target beat
    always_ff @(posedge i_clk) begin
        r_x0 <= i_target_x;
        r_y0 <= i_target_y;
        r_z0 <= i_target_z;
    end

    // Coxa angle from the raw target
    lik_cordic #(.W_IN(COORD_W), .STEPS(CORDIC_STEPS)) u_coxa (
        .i_clk   (i_clk),
        .i_y     (r_y0),
        .i_x     (r_x0),
        .o_angle (coxa_ang)
    );

    // Squares, horizontal distance squared, reach test
    assign xx_p = r_x0 * r_x0;
    assign yy_p = r_y0 * r_y0;
    assign zz_p = r_z0 * r_z0;

    always_ff @(posedge i_clk) begin
        r_xx    <= xx_p[L2_W-2:0];
        r_yy    <= yy_p[L2_W-2:0];
        r_zz    <= zz_p[L2_W-2:0];
        r_r2    <= L2_W'(r_xx) + L2_W'(r_yy);
        r_zz2   <= r_zz;
        r_reach <= ((L2_W+1)'(r_r2) + (L2_W+1)'(r_zz2)) < (L2_W+1)'(r_reach2);
    end

    // Horizontal reach L with eight fraction bits
    lik_isqrt #(.IN_W(LQ_IN_W)) u_sqrt_l (
        .i_clk  (i_clk),
        .i_val  ({r_r2, {(2*FRAC_SH){1'b0}}}),
        .o_root (lq)
    );

    // Hold z until L is ready
    always_ff @(posedge i_clk) begin
        r_zd[0] <= r_z0;
        for (int k = 1; k < D_Z; k++) begin
            r_zd[k] <= r_zd[k-1];
        end
    end

    // Offset by the coxa, square, sum
    assign zq_ext = LP_W'(r_zq);
    assign lp_sq  = r_lp * r_lp;
    assign zq_sq  = r_zq * r_zq;

    always_ff @(posedge i_clk) begin
        r_lp  <= $signed({1'b0, lq}) - $signed({{(LP_W-LEN_W-FRAC_SH){1'b0}}, r_coxa,
                                                {FRAC_SH{1'b0}}});
        r_zq  <= {r_zd[D_Z-1], {FRAC_SH{1'b0}}};
        r_lp2 <= lp_sq[D2_W-2:0];
        r_zq2 <= zq_sq[2*ZQ_W-2:0];
        r_d2  <= D2_W'(r_lp2) + D2_W'(r_zq2);
    end

    // First femur angle part, atan2(L', z)
    lik_cordic #(.W_IN(LP_W), .STEPS(CORDIC_STEPS)) u_a1 (
        .i_clk   (i_clk),
        .i_y     (r_lp),
        .i_x     (zq_ext),
        .o_angle (a1)
    );

    // Hip-to-foot distance D
    lik_isqrt #(.IN_W(D2_W)) u_sqrt_d (
        .i_clk  (i_clk),
        .i_val  (r_d2),
        .o_root (dq)
    );

    // Law-of-cosines products, then numerators and denominators
    assign fq   = {r_femur, {FRAC_SH{1'b0}}};
    assign tq   = {r_tibia, {FRAC_SH{1'b0}}};
    assign ff_p = fq * fq;
    assign tt_p = tq * tq;
    assign ft_p = fq * tq;
    assign dd_p = dq * dq;
    assign fd_p = fq * dq;

    always_ff @(posedge i_clk) begin
        r_ff   <= ff_p;
        r_tt   <= tt_p;
        r_ft   <= ft_p;
        r_dd   <= dd_p;
        r_fd   <= fd_p;
        r_num1 <= NUM_W'(r_ff) + NUM_W'(r_dd) - NUM_W'(r_tt);
        r_num2 <= NUM_W'(r_ff) + NUM_W'(r_tt) - NUM_W'(r_dd);
        r_den1 <= DEN_W'({r_fd, 1'b0});
        r_den2 <= DEN_W'({r_ft, 1'b0});
    end

    lik_ratio u_ratio_a2 (
        .i_clk   (i_clk),
        .i_num   (r_num1),
        .i_den   (r_den1),
        .o_ratio (c1)
    );

    lik_ratio u_ratio_b1 (
        .i_clk   (i_clk),
        .i_num   (r_num2),
        .i_den   (r_den2),
        .o_ratio (c2)
    );

    lik_acos #(.STEPS(CORDIC_STEPS)) u_acos_a2 (
        .i_clk   (i_clk),
        .i_c     (c1),
        .o_angle (a2)
    );

    lik_acos #(.STEPS(CORDIC_STEPS)) u_acos_b1 (
        .i_clk   (i_clk),
        .i_c     (c2),
        .o_angle (b1)
    );

    // Align the early results with the acos outputs
    always_ff @(posedge i_clk) begin
        r_coxa_d[0]  <= coxa_ang;
        r_a1_d[0]    <= a1;
        r_reach_d[0] <= r_reach;
        for (int k = 1; k < D_COXA; k++) begin
            r_coxa_d[k] <= r_coxa_d[k-1];
        end
        for (int k = 1; k < D_A1; k++) begin
            r_a1_d[k] <= r_a1_d[k-1];
        end
        for (int k = 1; k < D_REACH; k++) begin
            r_reach_d[k] <= r_reach_d[k-1];
        end
    end

    // Sum the joint angles, split sign and magnitude
    always_ff @(posedge i_clk) begin
        r_csum <= r_coxa_d[D_COXA-1] + ANG_45;
        r_fsum <= r_a1_d[D_A1-1] + a2;
        r_tsum <= ANG_180 - b1;
        r_cneg <= r_csum < 0;
        r_fneg <= r_fsum < 0;
        r_tneg <= r_tsum < 0;
        r_cmag <= (r_csum < 0) ? (ANG_W-1)'(-r_csum) : (ANG_W-1)'(r_csum);
        r_fmag <= (r_fsum < 0) ? (ANG_W-1)'(-r_fsum) : (ANG_W-1)'(r_fsum);
        r_tmag <= (r_tsum < 0) ? (ANG_W-1)'(-r_tsum) : (ANG_W-1)'(r_tsum);
    end

    assign c_cen = to_centi(r_cneg, r_cmag);
    assign f_cen = to_centi(r_fneg, r_fmag);
    assign t_cen = to_centi(r_tneg, r_tmag);

    // Round and drop in the fallback angles when out of reach
    always_ff @(posedge i_clk) begin
        r_coxa_out <= COXA_W'(c_cen);
        r_oor_out  <= !r_reach_d[D_REACH-1];
        if (r_reach_d[D_REACH-1]) begin
            r_femur_out <= FEMUR_W'(f_cen);
            r_tibia_out <= TIBIA_W'(t_cen);
        end else begin
            r_femur_out <= FEMUR_FALLBACK;
            r_tibia_out <= '0;
        end
    end

    assign o_done         = r_vld[NV-1];
    assign o_coxa_angle   = r_coxa_out;
    assign o_femur_angle  = r_femur_out;
    assign o_tibia_angle  = r_tibia_out;
    assign o_out_of_reach = r_oor_out;

endmodule
